FILE: design/ire_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the IPC rendezvous engine.
// No dependencies; used by ipc_rendezvous_engine and the testbench.
package ire_pkg;

   localparam int PID_W             = 6;
   localparam int MSG_W             = 32;
   localparam int DEF_PROCESS_COUNT = 32;
   localparam logic [PID_W-1:0] NONE_CODE = 6'd63;

   typedef enum logic [1:0] {
      REQ_SEND   = 2'd0,
      REQ_RECV   = 2'd1,
      REQ_NOTIFY = 2'd2,
      REQ_BAD    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      OUT_DELIVERED = 3'd0,
      OUT_BLOCKED   = 3'd1,
      OUT_INTR      = 3'd2,
      OUT_FLAG      = 3'd3,
      OUT_DEADLOCK  = 3'd4,
      OUT_INVALID   = 3'd5
   } outcome_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_CH_CHK,
      S_CH_WT,
      S_RS_WT,
      S_BLK_WR,
      S_AP_HWT,
      S_AP_CHK,
      S_AP_WT,
      S_RX_TGT_WT,
      S_RM_HWT,
      S_RM_CHK,
      S_RM_WT,
      S_RM_MSG
   } state_type;

endpackage

FILE: design/ire_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ire_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: design/ipc_rendezvous_engine.sv
`timescale 1ns / 1ps
// Top level of the IPC rendezvous engine: sequencer, per-process flags and tables.
// Depends on ire_pkg and ire_ram.
//
//  channel   ports                         handshake
//  request   req_type, req_caller_pid,     start & !busy accepts a beat
//            req_peer, req_message_payload
//  response  rsp_outcome .. rsp_wake_pid   rsp_strobe high for one cycle
//
// One request at a time; busy drops as its response is strobed.
// Invalid, notify and other requests settled in decode are strobed the cycle after.
// A send walks the target chain (a check and a wait state per hop) and then the
// target's queue in the same way; a receive walks its own queue. Every table
// lookup goes through one registered RAM read.
// Reset is synchronous and clears the flags at once; no clearing pass.
// The response cannot be stalled.
module ipc_rendezvous_engine #(
   parameter int PROCESS_COUNT = ire_pkg::DEF_PROCESS_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [4:0]  req_caller_pid,
   input  logic [5:0]  req_peer,
   input  logic [31:0] req_message_payload,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_outcome,
   output logic [4:0]  rsp_deliver_pid,
   output logic [5:0]  rsp_message_source,
   output logic [31:0] rsp_delivered_payload,
   output logic        rsp_wake_valid,
   output logic [4:0]  rsp_wake_pid
);

   localparam int PW = ire_pkg::PID_W;
   localparam int MW = ire_pkg::MSG_W;
   localparam int AW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
   localparam int SW = $clog2(PROCESS_COUNT + 1);
   localparam logic [PW-1:0] ANY_CODE  = PW'(PROCESS_COUNT);
   localparam logic [PW-1:0] INTR_CODE = PW'(PROCESS_COUNT + 1);
   localparam logic [SW-1:0] STEP_MAX  = SW'(PROCESS_COUNT);

   ire_pkg::state_type     state_ff, state_in;
   ire_pkg::req_kind_type  req_ff;
   logic [PW-1:0]          caller_ff, peer_ff;
   logic [MW-1:0]          pay_ff;
   logic [PW-1:0]          cur_ff, cur_in, prev_ff, prev_in, sel_ff, sel_in;
   logic                   pv_ff, pv_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [PROCESS_COUNT-1:0] smark_ff, smark_in, rmark_ff, rmark_in;
   logic [PROCESS_COUNT-1:0] pend_ff, pend_in, hval_ff, hval_in;

   logic                   fin;
   ire_pkg::outcome_type   fo;
   logic [4:0]             fd, fwp;
   logic [PW-1:0]          fs;
   logic [MW-1:0]          fp;
   logic                   fwv;

   logic                   strobe_ff;
   ire_pkg::outcome_type   out_ff;
   logic [4:0]             dpid_ff, wpid_ff;
   logic [PW-1:0]          src_ff;
   logic [MW-1:0]          opay_ff;
   logic                   wv_ff;

   // table ports: send target, receive source, queue head, queue link, held word
   logic          t_we, r_we, h_we, n_we, m_we;
   logic [AW-1:0] t_wa, r_wa, h_wa, n_wa, m_wa, t_ra, r_ra, h_ra, n_ra, m_ra;
   logic [PW-1:0] t_wd, r_wd, h_wd, n_wd, t_rd, r_rd, h_rd, n_rd;
   logic [MW-1:0] m_wd, m_rd;

   ire_ram #(.WIDTH(PW), .DEPTH(PROCESS_COUNT)) u_target (
      .clock(clock), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
   ire_ram #(.WIDTH(PW), .DEPTH(PROCESS_COUNT)) u_rsrc (
      .clock(clock), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
   ire_ram #(.WIDTH(PW), .DEPTH(PROCESS_COUNT)) u_head (
      .clock(clock), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
   ire_ram #(.WIDTH(PW), .DEPTH(PROCESS_COUNT)) u_next (
      .clock(clock), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
   ire_ram #(.WIDTH(MW), .DEPTH(PROCESS_COUNT)) u_held (
      .clock(clock), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

   logic [AW-1:0] cidx, pidx, curidx, previdx, selidx;
   logic c_proc, p_proc, cur_proc, steps_done;
   logic smark_c, rmark_c, pend_c, hval_c, smark_p, rmark_p, hval_p, smark_cur;
   logic dec_inv, dec_flag, dec_ok, dec_send, dec_intr, rx;
   logic dec_rx_any, dec_rx_proc, dec_rx_blk;
   logic ch_stop, ch_dead, rs_hit, ap_end, tg_hit, rm_stop, rm_hit;

   assign cidx    = caller_ff[AW-1:0];
   assign pidx    = peer_ff[AW-1:0];
   assign curidx  = cur_ff[AW-1:0];
   assign previdx = prev_ff[AW-1:0];
   assign selidx  = sel_ff[AW-1:0];

   assign c_proc   = caller_ff < ANY_CODE;
   assign p_proc   = peer_ff < ANY_CODE;
   assign cur_proc = cur_ff < ANY_CODE;
   assign steps_done = step_ff == STEP_MAX;

   assign smark_c   = c_proc ? smark_ff[cidx] : 1'b0;
   assign rmark_c   = c_proc ? rmark_ff[cidx] : 1'b0;
   assign pend_c    = c_proc ? pend_ff[cidx] : 1'b0;
   assign hval_c    = c_proc ? hval_ff[cidx] : 1'b0;
   assign smark_p   = p_proc ? smark_ff[pidx] : 1'b0;
   assign rmark_p   = p_proc ? rmark_ff[pidx] : 1'b0;
   assign hval_p    = p_proc ? hval_ff[pidx] : 1'b0;
   assign smark_cur = cur_proc ? smark_ff[curidx] : 1'b0;

   assign dec_inv  = (req_ff == ire_pkg::REQ_BAD) || !c_proc ||
                     ((req_ff != ire_pkg::REQ_NOTIFY) &&
                      (smark_c || rmark_c || peer_ff == caller_ff ||
                       (req_ff == ire_pkg::REQ_SEND && !p_proc) ||
                       (req_ff == ire_pkg::REQ_RECV && peer_ff > INTR_CODE)));
   assign dec_flag = !dec_inv && req_ff == ire_pkg::REQ_NOTIFY;
   assign dec_ok   = !dec_inv && req_ff != ire_pkg::REQ_NOTIFY;
   assign dec_send = dec_ok && req_ff == ire_pkg::REQ_SEND;
   assign dec_intr = dec_ok && req_ff == ire_pkg::REQ_RECV && pend_c &&
                     (peer_ff == ANY_CODE || peer_ff == INTR_CODE);
   assign rx          = dec_ok && req_ff == ire_pkg::REQ_RECV && !dec_intr;
   assign dec_rx_any  = rx && peer_ff == ANY_CODE && hval_c;
   assign dec_rx_proc = rx && p_proc && smark_p;
   assign dec_rx_blk  = rx && !dec_rx_any && !dec_rx_proc;

   assign ch_stop = steps_done || !cur_proc || !smark_cur;
   assign ch_dead = t_rd == caller_ff;
   assign rs_hit  = rmark_p && (r_rd == caller_ff || r_rd == ANY_CODE);
   assign ap_end  = n_rd >= ANY_CODE;
   assign tg_hit  = t_rd == caller_ff && hval_c;
   assign rm_stop = steps_done || !cur_proc;
   assign rm_hit  = cur_ff == sel_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ire_pkg::S_IDLE: begin
            if (start) state_in = ire_pkg::S_DECODE;
         end
         ire_pkg::S_DECODE: begin
            if (dec_send) state_in = ire_pkg::S_CH_CHK;
            else if (dec_rx_any) state_in = ire_pkg::S_RM_HWT;
            else if (dec_rx_proc) state_in = ire_pkg::S_RX_TGT_WT;
            else state_in = ire_pkg::S_IDLE;
         end
         ire_pkg::S_CH_CHK: begin
            state_in = ch_stop ? ire_pkg::S_RS_WT : ire_pkg::S_CH_WT;
         end
         ire_pkg::S_CH_WT: begin
            state_in = ch_dead ? ire_pkg::S_IDLE : ire_pkg::S_CH_CHK;
         end
         ire_pkg::S_RS_WT: begin
            state_in = rs_hit ? ire_pkg::S_IDLE : ire_pkg::S_BLK_WR;
         end
         ire_pkg::S_BLK_WR: begin
            state_in = hval_p ? ire_pkg::S_AP_HWT : ire_pkg::S_IDLE;
         end
         ire_pkg::S_AP_HWT: state_in = ire_pkg::S_AP_CHK;
         ire_pkg::S_AP_CHK: begin
            state_in = steps_done ? ire_pkg::S_IDLE : ire_pkg::S_AP_WT;
         end
         ire_pkg::S_AP_WT: begin
            state_in = ap_end ? ire_pkg::S_IDLE : ire_pkg::S_AP_CHK;
         end
         ire_pkg::S_RX_TGT_WT: begin
            state_in = tg_hit ? ire_pkg::S_RM_HWT : ire_pkg::S_IDLE;
         end
         ire_pkg::S_RM_HWT: state_in = ire_pkg::S_RM_CHK;
         ire_pkg::S_RM_CHK: begin
            state_in = rm_stop ? ire_pkg::S_IDLE : ire_pkg::S_RM_WT;
         end
         ire_pkg::S_RM_WT: begin
            state_in = rm_hit ? ire_pkg::S_RM_MSG : ire_pkg::S_RM_CHK;
         end
         ire_pkg::S_RM_MSG: state_in = ire_pkg::S_IDLE;
         default: state_in = ire_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic blk_rx;
      blk_rx   = 1'b0;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      pv_in    = pv_ff;
      sel_in   = sel_ff;
      step_in  = step_ff;
      smark_in = smark_ff;
      rmark_in = rmark_ff;
      pend_in  = pend_ff;
      hval_in  = hval_ff;
      fin = 1'b0;
      fo  = ire_pkg::OUT_INVALID;
      fd  = '0;
      fs  = '0;
      fp  = '0;
      fwv = 1'b0;
      fwp = '0;
      t_we = 1'b0; t_wa = cidx; t_wd = peer_ff; t_ra = curidx;
      r_we = 1'b0; r_wa = cidx; r_wd = peer_ff; r_ra = pidx;
      h_we = 1'b0; h_wa = pidx; h_wd = caller_ff; h_ra = pidx;
      n_we = 1'b0; n_wa = curidx; n_wd = caller_ff; n_ra = curidx;
      m_we = 1'b0; m_wa = cidx; m_wd = pay_ff; m_ra = selidx;
      case (state_ff)
         ire_pkg::S_DECODE: begin
            sel_in  = peer_ff;
            cur_in  = peer_ff;
            step_in = '0;
            if (dec_inv) begin
               fin = 1'b1;
            end else if (dec_flag) begin
               pend_in[cidx] = 1'b1;
               fin = 1'b1;
               fo  = ire_pkg::OUT_FLAG;
            end else if (dec_intr) begin
               pend_in[cidx] = 1'b0;
               fin = 1'b1;
               fo  = ire_pkg::OUT_INTR;
               fd  = caller_ff[4:0];
               fs  = INTR_CODE;
            end else if (dec_rx_any) begin
               h_ra = cidx;
            end else if (dec_rx_proc) begin
               t_ra = pidx;
            end else if (dec_rx_blk) begin
               blk_rx = 1'b1;
            end
         end
         ire_pkg::S_CH_CHK: begin
            t_ra = curidx;
            r_ra = pidx;
         end
         ire_pkg::S_CH_WT: begin
            if (ch_dead) begin
               fin = 1'b1;
               fo  = ire_pkg::OUT_DEADLOCK;
            end else begin
               cur_in  = t_rd;
               step_in = step_ff + 1'b1;
            end
         end
         ire_pkg::S_RS_WT: begin
            if (rs_hit) begin
               rmark_in[pidx] = 1'b0;
               fin = 1'b1;
               fo  = ire_pkg::OUT_DELIVERED;
               fd  = peer_ff[4:0];
               fs  = caller_ff;
               fp  = pay_ff;
               fwv = 1'b1;
               fwp = peer_ff[4:0];
            end
         end
         ire_pkg::S_BLK_WR: begin
            smark_in[cidx] = 1'b1;
            t_we = 1'b1;
            m_we = 1'b1;
            n_we = 1'b1;
            n_wa = cidx;
            n_wd = ire_pkg::NONE_CODE;
            h_ra = pidx;
            if (!hval_p) begin
               h_we = 1'b1;
               hval_in[pidx] = 1'b1;
               fin = 1'b1;
               fo  = ire_pkg::OUT_BLOCKED;
            end
         end
         ire_pkg::S_AP_HWT: begin
            cur_in  = h_rd;
            step_in = '0;
         end
         ire_pkg::S_AP_CHK: begin
            n_ra = curidx;
            if (steps_done) begin
               n_we = 1'b1;
               fin  = 1'b1;
               fo   = ire_pkg::OUT_BLOCKED;
            end
         end
         ire_pkg::S_AP_WT: begin
            if (ap_end) begin
               n_we = 1'b1;
               fin  = 1'b1;
               fo   = ire_pkg::OUT_BLOCKED;
            end else begin
               cur_in  = n_rd;
               step_in = step_ff + 1'b1;
            end
         end
         ire_pkg::S_RX_TGT_WT: begin
            h_ra = cidx;
            if (!tg_hit) blk_rx = 1'b1;
         end
         ire_pkg::S_RM_HWT: begin
            cur_in  = h_rd;
            pv_in   = 1'b0;
            step_in = '0;
            if (peer_ff == ANY_CODE) sel_in = h_rd;
         end
         ire_pkg::S_RM_CHK: begin
            n_ra = curidx;
            if (rm_stop) blk_rx = 1'b1;
         end
         ire_pkg::S_RM_WT: begin
            m_ra = selidx;
            if (rm_hit) begin
               // unlink the found sender
               if (pv_ff) begin
                  n_we = 1'b1;
                  n_wa = previdx;
                  n_wd = n_rd;
               end else begin
                  h_we = 1'b1;
                  h_wa = cidx;
                  h_wd = n_rd;
                  hval_in[cidx] = n_rd < ANY_CODE;
               end
            end else begin
               prev_in = cur_ff;
               pv_in   = 1'b1;
               cur_in  = n_rd;
               step_in = step_ff + 1'b1;
            end
         end
         ire_pkg::S_RM_MSG: begin
            smark_in[selidx] = 1'b0;
            fin = 1'b1;
            fo  = ire_pkg::OUT_DELIVERED;
            fd  = caller_ff[4:0];
            fs  = sel_ff;
            fp  = m_rd;
            fwv = 1'b1;
            fwp = sel_ff[4:0];
         end
         default: begin
         end
      endcase
      if (blk_rx) begin
         rmark_in[cidx] = 1'b1;
         r_we = 1'b1;
         r_wa = cidx;
         r_wd = peer_ff;
         fin  = 1'b1;
         fo   = ire_pkg::OUT_BLOCKED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ire_pkg::S_IDLE;
         smark_ff  <= '0;
         rmark_ff  <= '0;
         pend_ff   <= '0;
         hval_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         smark_ff  <= smark_in;
         rmark_ff  <= rmark_in;
         pend_ff   <= pend_in;
         hval_ff   <= hval_in;
         strobe_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ire_pkg::S_IDLE && start) begin
         req_ff    <= ire_pkg::req_kind_type'(req_type);
         caller_ff <= {1'b0, req_caller_pid};
         peer_ff   <= req_peer;
         pay_ff    <= req_message_payload;
      end
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      pv_ff   <= pv_in;
      sel_ff  <= sel_in;
      step_ff <= step_in;
      if (fin) begin
         out_ff  <= fo;
         dpid_ff <= fd;
         src_ff  <= fs;
         opay_ff <= fp;
         wv_ff   <= fwv;
         wpid_ff <= fwp;
      end
   end

   assign busy                  = state_ff != ire_pkg::S_IDLE;
   assign rsp_strobe            = strobe_ff;
   assign rsp_outcome           = out_ff;
   assign rsp_deliver_pid       = dpid_ff;
   assign rsp_message_source    = src_ff;
   assign rsp_delivered_payload = opay_ff;
   assign rsp_wake_valid        = wv_ff;
   assign rsp_wake_pid          = wpid_ff;

endmodule

FILE: test/tb_ipc_rendezvous_engine.sv
`timescale 1ns / 1ps
// Self-checking bench for ipc_rendezvous_engine: a software copy of the rendezvous
// tables predicts every response beat. Depends on ire_pkg and the design files.
module tb_ipc_rendezvous_engine;

   localparam int NPROC = ire_pkg::DEF_PROCESS_COUNT;
   localparam logic [5:0] PEER_ANY  = 6'd32;
   localparam logic [5:0] PEER_INTR = 6'd33;

   typedef struct packed {
      ire_pkg::req_kind_type kind;
      logic [4:0]   caller;
      logic [5:0]   peer;
      logic [31:0]  word;
   } rdv_req_type;

   typedef struct packed {
      ire_pkg::outcome_type outcome;
      logic [4:0]   dpid;
      logic [5:0]   src;
      logic [31:0]  word;
      logic         wv;
      logic [4:0]   wpid;
   } rdv_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [4:0]  req_caller_pid = '0;
   logic [5:0]  req_peer = '0;
   logic [31:0] req_message_payload = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_outcome;
   logic [4:0]  rsp_deliver_pid;
   logic [5:0]  rsp_message_source;
   logic [31:0] rsp_delivered_payload;
   logic        rsp_wake_valid;
   logic [4:0]  rsp_wake_pid;

   ipc_rendezvous_engine u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   bit          snd_mk [NPROC];
   bit          rcv_mk [NPROC];
   logic [5:0]  snd_tgt [NPROC];
   logic [5:0]  rcv_src [NPROC];
   logic [31:0] held [NPROC];
   logic [5:0]  q_head [NPROC];
   logic [5:0]  q_next [NPROC];
   bit          irq_pend [NPROC];

   rdv_req_type pending_reqs[$];
   rdv_rsp_type expected_rsps[$];
   int       n_errors = 0, n_sent = 0, n_checked = 0, n_delivered = 0;
   int       send_idle_pct = 0;
   bit       stim_done = 0;

   function automatic bit is_pid(logic [5:0] v);
      return v < NPROC;
   endfunction

   function automatic void clear_tables();
      for (int i = 0; i < NPROC; i++) begin
         snd_mk[i] = 0; rcv_mk[i] = 0; irq_pend[i] = 0; held[i] = '0;
         snd_tgt[i] = ire_pkg::NONE_CODE; rcv_src[i] = ire_pkg::NONE_CODE;
         q_head[i] = ire_pkg::NONE_CODE; q_next[i] = ire_pkg::NONE_CODE;
      end
   endfunction

   function automatic bit chain_hits(logic [5:0] from, logic [4:0] caller);
      logic [5:0] p;
      p = from;
      for (int k = 0; k < NPROC; k++) begin
         if (!is_pid(p) || !snd_mk[p]) return 0;
         p = snd_tgt[p];
         if (p == {1'b0, caller}) return 1;
      end
      return 0;
   endfunction

   function automatic void enqueue_sender(logic [5:0] dest, logic [4:0] who);
      logic [5:0] p;
      p = q_head[dest];
      q_next[who] = ire_pkg::NONE_CODE;
      if (!is_pid(p)) begin
         q_head[dest] = {1'b0, who};
         return;
      end
      for (int k = 0; k < NPROC; k++) begin
         if (!is_pid(q_next[p])) break;
         p = q_next[p];
      end
      q_next[p] = {1'b0, who};
   endfunction

   function automatic bit unlink_sender(logic [4:0] dest, logic [5:0] who);
      logic [5:0] p, prev;
      p = q_head[dest];
      prev = ire_pkg::NONE_CODE;
      for (int k = 0; k < NPROC && is_pid(p); k++) begin
         if (p == who) begin
            if (is_pid(prev)) q_next[prev] = q_next[p];
            else q_head[dest] = q_next[p];
            q_next[p] = ire_pkg::NONE_CODE;
            return 1;
         end
         prev = p;
         p = q_next[p];
      end
      return 0;
   endfunction

   function automatic rdv_rsp_type rendezvous_predict(rdv_req_type r);
      rdv_rsp_type o;
      logic [5:0] s;
      o = '{outcome: ire_pkg::OUT_INVALID, default: '0};
      if (r.kind == ire_pkg::REQ_BAD) return o;
      if (r.kind == ire_pkg::REQ_NOTIFY) begin
         irq_pend[r.caller] = 1;
         o.outcome = ire_pkg::OUT_FLAG;
         return o;
      end
      if (snd_mk[r.caller] || rcv_mk[r.caller] || r.peer == {1'b0, r.caller}) return o;
      if (r.kind == ire_pkg::REQ_SEND) begin
         if (!is_pid(r.peer)) return o;
         if (chain_hits(r.peer, r.caller)) begin
            o.outcome = ire_pkg::OUT_DEADLOCK;
            return o;
         end
         if (rcv_mk[r.peer] && (rcv_src[r.peer] == {1'b0, r.caller} ||
                                rcv_src[r.peer] == PEER_ANY)) begin
            rcv_mk[r.peer] = 0;
            rcv_src[r.peer] = ire_pkg::NONE_CODE;
            o = '{ire_pkg::OUT_DELIVERED, r.peer[4:0], {1'b0, r.caller}, r.word, 1'b1,
                  r.peer[4:0]};
            return o;
         end
         snd_mk[r.caller] = 1;
         snd_tgt[r.caller] = r.peer;
         held[r.caller] = r.word;
         enqueue_sender(r.peer, r.caller);
         o.outcome = ire_pkg::OUT_BLOCKED;
         return o;
      end
      if (r.peer > PEER_INTR) return o;
      if (irq_pend[r.caller] && (r.peer == PEER_ANY || r.peer == PEER_INTR)) begin
         irq_pend[r.caller] = 0;
         o = '{ire_pkg::OUT_INTR, r.caller, PEER_INTR, 32'd0, 1'b0, 5'd0};
         return o;
      end
      s = ire_pkg::NONE_CODE;
      if (r.peer == PEER_ANY) begin
         if (is_pid(q_head[r.caller])) s = q_head[r.caller];
      end else if (is_pid(r.peer)) begin
         if (snd_mk[r.peer] && snd_tgt[r.peer] == {1'b0, r.caller}) s = r.peer;
      end
      if (is_pid(s) && unlink_sender(r.caller, s)) begin
         snd_mk[s] = 0;
         snd_tgt[s] = ire_pkg::NONE_CODE;
         o = '{ire_pkg::OUT_DELIVERED, r.caller, s, held[s], 1'b1, s[4:0]};
         return o;
      end
      rcv_mk[r.caller] = 1;
      rcv_src[r.caller] = r.peer;
      o.outcome = ire_pkg::OUT_BLOCKED;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      n_errors++;
      $display("mismatch beat %0d: %s got 0x%0h want 0x%0h", n_checked, what, got, want);
   endtask

   // driver: keeps start high across back-to-back beats
   always @(posedge clock) begin
      if (!reset) begin
         if (!start || !busy) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               rdv_req_type r;
               r = pending_reqs.pop_front();
               start <= 1'b1;
               req_type <= r.kind;
               req_caller_pid <= r.caller;
               req_peer <= r.peer;
               req_message_payload <= r.word;
               expected_rsps.push_back(rendezvous_predict(r));
               n_sent++;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rdv_rsp_type e;
         if (expected_rsps.size() == 0) begin
            n_errors++;
            $display("unexpected response beat");
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_outcome != e.outcome)
               report_mismatch("outcome", 32'(rsp_outcome), 32'(e.outcome));
            if (rsp_deliver_pid != e.dpid)
               report_mismatch("deliver_pid", 32'(rsp_deliver_pid), 32'(e.dpid));
            if (rsp_message_source != e.src)
               report_mismatch("message_source", 32'(rsp_message_source), 32'(e.src));
            if (rsp_delivered_payload != e.word)
               report_mismatch("payload", rsp_delivered_payload, e.word);
            if (rsp_wake_valid != e.wv)
               report_mismatch("wake_valid", 32'(rsp_wake_valid), 32'(e.wv));
            if (rsp_wake_pid != e.wpid)
               report_mismatch("wake_pid", 32'(rsp_wake_pid), 32'(e.wpid));
            if (e.outcome == ire_pkg::OUT_DELIVERED) n_delivered++;
            n_checked++;
         end
      end
   end

   function automatic rdv_req_type mk(ire_pkg::req_kind_type k, int c, int p,
                                      logic [31:0] w);
      return '{k, c[4:0], p[5:0], w};
   endfunction

   // random item: mostly sends/receives among a small group so that
   // queues, rendezvous and deadlock chains actually form
   function automatic rdv_req_type rand_req();
      int g, c, p, sel;
      g = ($urandom_range(3) == 0) ? 31 : 5;
      c = $urandom_range(g);
      sel = $urandom_range(99);
      if (sel < 3)
         return mk(ire_pkg::REQ_BAD, $urandom_range(31), $urandom_range(63), $urandom);
      if (sel < 10) return mk(ire_pkg::REQ_NOTIFY, c, $urandom_range(63), $urandom);
      if (sel < 13)
         return mk(sel < 12 ? ire_pkg::REQ_SEND : ire_pkg::REQ_RECV, c,
                   $urandom_range(34, 63), $urandom);
      if (sel < 55) begin
         p = $urandom_range(g);
         if ($urandom_range(9) == 0) p = $urandom_range(32, 33);
         return mk(ire_pkg::REQ_SEND, c, p, $urandom);
      end
      p = $urandom_range(9);
      if (p < 3) p = 32;
      else if (p < 4) p = 33;
      else p = $urandom_range(g);
      return mk(ire_pkg::REQ_RECV, c, p, $urandom);
   endfunction

   initial begin
      clear_tables();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // directed: bad type, self send, any/interrupt targets, rendezvous both ways,
      // queueing, named unlink, deadlock, interrupt receive, receive from bad peer
      pending_reqs.push_back(mk(ire_pkg::REQ_BAD, 31, 63, 32'hFFFF_FFFF));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 0, 0, 32'h1));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 0, 32, 32'h2));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 0, 33, 32'h3));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 0, 34, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 31, 63, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 1, 32, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 2, 1, 32'hFFFF_FFFF));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 3, 4, 32'hA5A5_0001));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 5, 4, 32'hA5A5_0002));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 6, 4, 32'hA5A5_0003));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 3, 5, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 4, 3, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 4, 5, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 4, 32, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 4, 32, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_NOTIFY, 7, 63, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 7, 33, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 8, 33, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_NOTIFY, 8, 0, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_SEND, 8, 9, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_NOTIFY, 31, 0, 32'h0));
      pending_reqs.push_back(mk(ire_pkg::REQ_RECV, 31, 32, 32'h0));
      for (int ph = 0; ph < 4; ph++) begin
         wait (pending_reqs.size() == 0);
         send_idle_pct = (ph == 1) ? 59 : (ph == 3) ? 38 : 0;
         for (int i = 0; i < 120; i++) pending_reqs.push_back(rand_req());
      end
      wait (pending_reqs.size() == 0);
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (busy || start || expected_rsps.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("ran %0d requests, %0d responses checked, %0d messages delivered",
               n_sent, n_checked, n_delivered);
      if (n_errors == 0 && expected_rsps.size() == 0)
         $display("** ipc_rendezvous_engine: PASSED **");
      else
         $display("** ipc_rendezvous_engine: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** ipc_rendezvous_engine: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
design/ire_pkg.sv
design/ire_ram.sv
design/ipc_rendezvous_engine.sv
test/tb_ipc_rendezvous_engine.sv
